// ===== design/rpfw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the resource pool with FIFO waiters: beat types, status codes,
// controller command struct and parameter defaults. No dependencies.
package rpfw_pkg;

  // Parameter defaults
  localparam int unsigned MaxPoolDefault    = 8;
  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned IdWidthDefault    = 8;

  // Fixed field widths
  localparam int unsigned PoolW   = 4;
  localparam int unsigned ClientW = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned WaitW   = 5;

  // Pool size after reset
  localparam logic [PoolW-1:0] PoolSizeReset = PoolW'(8);

  // Status codes
  localparam logic [StatusW-1:0] StGranted     = 3'd0;
  localparam logic [StatusW-1:0] StQueued      = 3'd1;
  localparam logic [StatusW-1:0] StRejected    = 3'd2;
  localparam logic [StatusW-1:0] StRelGranted  = 3'd3;
  localparam logic [StatusW-1:0] StRelNoWaiter = 3'd4;
  localparam logic [StatusW-1:0] StRelIgnored  = 3'd5;

  // Opcodes
  localparam logic OpRequest = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [ClientW-1:0] client_id;
  } rpfw_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               next_valid;
    logic [ClientW-1:0] next_id;
    logic [PoolW-1:0]   free_count;
    logic [WaitW-1:0]   wait_count;
  } rpfw_rsp_t;

  typedef struct packed {
    logic load;  // capture the request beat
    logic exec;  // decide and update pool state
  } rpfw_cmd_t;

endpackage

// ===== design/rpfw_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the resource pool: idle/execute sequencer and result strobe.
// Depends on rpfw_pkg.
module rpfw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  output rpfw_pkg::rpfw_cmd_t cmd_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SExec = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SExec;
        end
      end
      SExec: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign cmd_o.load = (state_q == SIdle) && start_i;
  assign cmd_o.exec = (state_q == SExec);
  assign done_d     = cmd_o.exec;
  assign busy_o     = (state_q == SExec);
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== design/rpfw_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the resource pool: holder slots, wait queue memory, counters
// and the result register. Depends on rpfw_pkg.
module rpfw_dp #(
  parameter int unsigned MAX_POOL    = rpfw_pkg::MaxPoolDefault,
  parameter int unsigned QUEUE_DEPTH = rpfw_pkg::QueueDepthDefault,
  parameter int unsigned ID_WIDTH    = rpfw_pkg::IdWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpfw_pkg::rpfw_cmd_t           cmd_i,
  input  rpfw_pkg::rpfw_req_t           req_i,
  input  logic                          cfg_we_i,
  input  logic [rpfw_pkg::PoolW-1:0]    cfg_wdata_i,
  output rpfw_pkg::rpfw_rsp_t           rsp_o
);

  localparam int unsigned SlotW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW    = rpfw_pkg::PoolW;

  // Request beat
  logic                op_q;
  logic [ID_WIDTH-1:0] id_q;

  // Holder slots
  logic [ID_WIDTH-1:0] hold_id_q [MAX_POOL];
  logic [MAX_POOL-1:0] hold_vld_q, hold_vld_d;
  logic                hold_we;
  logic [SlotW-1:0]    hold_idx;
  logic [ID_WIDTH-1:0] hold_wid;

  // Wait queue
  logic [ID_WIDTH-1:0] wq_mem [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] wq_rd_q;
  logic                wq_we;
  logic [QW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [PW-1:0]       free_q, free_d;

  rpfw_pkg::rpfw_rsp_t rsp_q, rsp_d;

  // Slot search
  logic             fs_found, mt_found;
  logic [SlotW-1:0] fs_idx, mt_idx;

  // Lowest empty slot and lowest valid slot holding the id
  always_comb begin
    fs_found = 1'b0;
    fs_idx   = '0;
    mt_found = 1'b0;
    mt_idx   = '0;
    for (int i = 0; i < MAX_POOL; i++) begin
      if (!fs_found && !hold_vld_q[i]) begin
        fs_found = 1'b1;
        fs_idx   = SlotW'(i);
      end
      if (!mt_found && hold_vld_q[i] && (hold_id_q[i] == id_q)) begin
        mt_found = 1'b1;
        mt_idx   = SlotW'(i);
      end
    end
  end

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
    wrap_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    hold_vld_d = hold_vld_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    free_d     = free_q;
    hold_we    = 1'b0;
    hold_idx   = fs_idx;
    hold_wid   = id_q;
    wq_we      = 1'b0;
    rsp_d      = rsp_q;
    if (cfg_we_i) begin
      // New pool size drops holders and waiters
      hold_vld_d = '0;
      head_d     = '0;
      tail_d     = '0;
      fill_d     = '0;
      free_d     = (cfg_wdata_i > MAX_POOL) ? PW'(MAX_POOL) : cfg_wdata_i;
    end else if (cmd_i.exec) begin
      rsp_d.next_valid = 1'b0;
      rsp_d.next_id    = '0;
      if (op_q == rpfw_pkg::OpRequest) begin
        if ((free_q != '0) && fs_found) begin
          hold_we            = 1'b1;
          hold_vld_d[fs_idx] = 1'b1;
          free_d             = free_q - 1'b1;
          rsp_d.status       = rpfw_pkg::StGranted;
        end else if (fill_q < QUEUE_DEPTH) begin
          wq_we        = 1'b1;
          tail_d       = wrap_inc(tail_q);
          fill_d       = fill_q + 1'b1;
          rsp_d.status = rpfw_pkg::StQueued;
        end else begin
          rsp_d.status = rpfw_pkg::StRejected;
        end
      end else begin
        if (!mt_found) begin
          rsp_d.status = rpfw_pkg::StRelIgnored;
        end else if (fill_q != '0) begin
          // Hand the slot straight to the oldest waiter
          hold_we          = 1'b1;
          hold_idx         = mt_idx;
          hold_wid         = wq_rd_q;
          head_d           = wrap_inc(head_q);
          fill_d           = fill_q - 1'b1;
          rsp_d.status     = rpfw_pkg::StRelGranted;
          rsp_d.next_valid = 1'b1;
          rsp_d.next_id    = rpfw_pkg::ClientW'(wq_rd_q);
        end else begin
          hold_vld_d[mt_idx] = 1'b0;
          free_d             = free_q + 1'b1;
          rsp_d.status       = rpfw_pkg::StRelNoWaiter;
        end
      end
      rsp_d.free_count = free_d;
      rsp_d.wait_count = rpfw_pkg::WaitW'(fill_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      free_q     <= (rpfw_pkg::PoolSizeReset > MAX_POOL) ? PW'(MAX_POOL)
                                                         : rpfw_pkg::PoolSizeReset;
    end else begin
      hold_vld_q <= hold_vld_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      free_q     <= free_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i.opcode;
      id_q <= ID_WIDTH'(req_i.client_id);
    end
    if (hold_we) begin
      hold_id_q[hold_idx] <= hold_wid;
    end
    rsp_q <= rsp_d;
  end

  // Queue memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (wq_we) begin
      wq_mem[tail_q] <= id_q;
    end
    wq_rd_q <= wq_mem[head_q];
  end

  assign rsp_o = rsp_q;

endmodule

// ===== design/resource_pool_fifo_waiters.sv =====
`timescale 1ns / 1ps
// Resource pool with FIFO waiters. An accepted beat enters the execute state,
// whose result and strobe are registered. Busy is high while executing, so no
// new beat is taken until it ends (accept, execute); the head of the wait
// queue is read from its memory ahead of the execute cycle.
// Reset (async, active low): pool size 8, no holders, empty queue, no clearing
// pass. A pool_size write restarts the pool with the new size, clamped to
// MAX_POOL. Results are strobed for one cycle; the receiver cannot stall.
// Depends on rpfw_pkg, rpfw_ctrl, rpfw_dp.
module resource_pool_fifo_waiters #(
  parameter int unsigned MAX_POOL    = rpfw_pkg::MaxPoolDefault,
  parameter int unsigned QUEUE_DEPTH = rpfw_pkg::QueueDepthDefault,
  parameter int unsigned ID_WIDTH    = rpfw_pkg::IdWidthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request beat: taken when start is high and busy is low
  input  logic                       start,
  output logic                       busy,
  input  rpfw_pkg::rpfw_req_t        req_i,
  // result beat: valid for exactly one cycle
  output logic                       rsp_valid_o,
  output rpfw_pkg::rpfw_rsp_t        rsp_o,
  // pool_size register
  input  logic                       cfg_we_i,
  input  logic [rpfw_pkg::PoolW-1:0] cfg_wdata_i
);

  rpfw_pkg::rpfw_cmd_t cmd;

  // Sequencer: idle, then an execute step for each beat
  rpfw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (rsp_valid_o),
    .cmd_o   (cmd)
  );

  // Holder search, queue memory and counters
  rpfw_dp #(
    .MAX_POOL    (MAX_POOL),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

  // Every accepted beat yields its result strobe after the execute state
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 rsp_valid_o)
    else $error("accepted beat produced no result");

  // The block is free again when a result is shown
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("busy while result shown");

  // A waiter is reported exactly on a release that hands over
  a_next_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.next_valid == (rsp_o.status == rpfw_pkg::StRelGranted)))
    else $error("next_valid disagrees with status");

  // No waiter means a zero id
  a_next_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.next_valid) |-> (rsp_o.next_id == '0))
    else $error("next_id nonzero without waiter");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for resource_pool_fifo_waiters: grants, wait queue,
// handover on release and pool_size restarts, checked against a local model.
// Depends on rpfw_pkg and the resource_pool_fifo_waiters RTL.
module tb_top;
  import rpfw_pkg::*;

  localparam int unsigned MaxPool    = MaxPoolDefault;
  localparam int unsigned QueueDepth = QueueDepthDefault;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  rpfw_req_t        req_beat;
  logic             rsp_valid_o;
  rpfw_rsp_t        rsp_o;
  logic             cfg_we;
  logic [PoolW-1:0] cfg_wdata;

  resource_pool_fifo_waiters dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_beat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Pool model: free count, holder slots and the wait queue, as the block
  // should hold them after every accepted beat.
  // ---------------------------------------------------------------------------
  logic [PoolW-1:0]   pool_cfg;
  logic [PoolW-1:0]   pool_free;
  logic [ClientW-1:0] slot_id   [MaxPool];
  logic               slot_used [MaxPool];
  logic [ClientW-1:0] waitq     [QueueDepth];
  int unsigned        waitq_head;
  int unsigned        waitq_tail;
  logic [WaitW-1:0]   waitq_fill;

  rpfw_rsp_t expected_answers[$];
  int unsigned mismatches = 0;

  // A pool_size write drops holders and waiters and restarts with the new size;
  // sizes above the holder capacity are clamped to it.
  function automatic void pool_restart(input logic [PoolW-1:0] size);
    pool_cfg  = size;
    pool_free = (size > MaxPool) ? PoolW'(MaxPool) : size;
    for (int i = 0; i < MaxPool; i++) begin
      slot_used[i] = 1'b0;
      slot_id[i]   = '0;
    end
    for (int i = 0; i < QueueDepth; i++) waitq[i] = '0;
    waitq_head = 0;
    waitq_tail = 0;
    waitq_fill = '0;
  endfunction

  function automatic rpfw_rsp_t pool_step(input rpfw_req_t beat);
    rpfw_rsp_t ans;
    int        hit;
    ans = '0;
    hit = -1;
    if (beat.opcode == OpRequest) begin
      for (int i = 0; i < MaxPool; i++)
        if (!slot_used[i] && hit < 0) hit = i;
      if (pool_free > 0 && hit >= 0) begin
        pool_free--;
        slot_id[hit]   = beat.client_id;
        slot_used[hit] = 1'b1;
        ans.status     = StGranted;
      end else if (waitq_fill < QueueDepth) begin
        waitq[waitq_tail] = beat.client_id;
        waitq_tail = (waitq_tail == QueueDepth - 1) ? 0 : waitq_tail + 1;
        waitq_fill++;
        ans.status = StQueued;
      end else begin
        ans.status = StRejected;
      end
    end else begin
      // lowest numbered slot holding the id wins
      for (int i = 0; i < MaxPool; i++)
        if (slot_used[i] && slot_id[i] == beat.client_id && hit < 0) hit = i;
      if (hit < 0) begin
        ans.status = StRelIgnored;
      end else begin
        slot_used[hit] = 1'b0;
        pool_free++;
        if (waitq_fill > 0 && pool_free > 0) begin
          // hand the freed resource straight to the oldest waiter
          ans.next_id    = waitq[waitq_head];
          ans.next_valid = 1'b1;
          waitq_head = (waitq_head == QueueDepth - 1) ? 0 : waitq_head + 1;
          waitq_fill--;
          pool_free--;
          slot_id[hit]   = ans.next_id;
          slot_used[hit] = 1'b1;
          ans.status     = StRelGranted;
        end else begin
          ans.status = StRelNoWaiter;
        end
      end
    end
    ans.free_count = pool_free;
    ans.wait_count = waitq_fill;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobed beat must match the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rpfw_rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result beat: status=%0d next=%0d/%02h free=%0d wait=%0d",
                   rsp_o.status, rsp_o.next_valid, rsp_o.next_id,
                   rsp_o.free_count, rsp_o.wait_count);
      end else begin
        want = expected_answers.pop_front();
        if (rsp_o.status !== want.status || rsp_o.next_valid !== want.next_valid ||
            rsp_o.next_id !== want.next_id || rsp_o.free_count !== want.free_count ||
            rsp_o.wait_count !== want.wait_count) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("mismatch: expected status=%0d next=%0d/%02h free=%0d wait=%0d",
                     want.status, want.next_valid, want.next_id, want.free_count,
                     want.wait_count);
            $display("          got      status=%0d next=%0d/%02h free=%0d wait=%0d",
                     rsp_o.status, rsp_o.next_valid, rsp_o.next_id,
                     rsp_o.free_count, rsp_o.wait_count);
          end
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || rsp_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------

  // Hold start and the beat until the block takes it, then predict.
  // Start is left high: the caller either sends again in this step or drops it.
  task automatic issue_beat(input logic op, input logic [ClientW-1:0] id);
    rpfw_req_t beat;
    beat.opcode    = op;
    beat.client_id = id;
    start    <= 1'b1;
    req_beat <= beat;
    do @(posedge clk_i); while (busy);
    expected_answers = {expected_answers, pool_step(beat)};
  endtask

  task automatic sender_gap(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has come back.
  // Always advance at least one edge so back-to-back calls drive start once.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_answers.size() != 0);
  endtask

  // Write pool_size only with the block idle: drain, let it settle, then write.
  task automatic write_pool_size(input logic [PoolW-1:0] size);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pool_restart(size);
  endtask

  // Pick a release target: mostly a current holder, sometimes a waiter
  // (not a holder, so usually ignored), sometimes any id.
  function automatic logic [ClientW-1:0] pick_release_id();
    logic [ClientW-1:0] held[$];
    int unsigned        roll;
    roll = $urandom_range(0, 9);
    for (int i = 0; i < MaxPool; i++)
      if (slot_used[i]) held = {held, slot_id[i]};
    if (roll <= 5 && held.size() != 0)
      return held[$urandom_range(0, held.size() - 1)];
    if (roll <= 7 && waitq_fill != 0)
      return waitq[(waitq_head + $urandom_range(0, waitq_fill - 1)) % QueueDepth];
    return ClientW'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One resource: grant, queue a duplicate id, ignore a stranger, hand over
  // twice in queue order, then release with nobody waiting.
  task automatic test_handover();
    write_pool_size(PoolW'(1));
    issue_beat(OpRequest, 8'h00);
    issue_beat(OpRequest, 8'hFF);
    issue_beat(OpRequest, 8'h00);
    issue_beat(OpRelease, 8'h5A);
    issue_beat(OpRelease, 8'h00);
    issue_beat(OpRelease, 8'hFF);
    issue_beat(OpRelease, 8'h00);
    drain_results();
  endtask

  // Empty pool: every request queues until the queue is full, the next one is
  // rejected, and a release finds no holder.
  task automatic test_queue_limit();
    write_pool_size(PoolW'(0));
    issue_beat(OpRequest, 8'hFF);
    issue_beat(OpRequest, 8'h00);
    for (int i = 2; i < QueueDepth; i++) issue_beat(OpRequest, ClientW'($urandom_range(0, 255)));
    issue_beat(OpRequest, 8'hA5);
    issue_beat(OpRelease, 8'hFF);
    drain_results();
  endtask

  // Random traffic on the current pool size. Ids come mostly from a small set
  // so requests collide and releases hit holders.
  task automatic run_traffic(input int unsigned items, input int unsigned req_pct,
                             input bit with_gaps);
    logic [ClientW-1:0] id;
    for (int n = 0; n < items; n++) begin
      if (with_gaps && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 6));
      if ($urandom_range(0, 99) < req_pct) begin
        if ($urandom_range(0, 1) == 0) id = ClientW'($urandom_range(0, 15));
        else id = ClientW'($urandom_range(0, 255));
        issue_beat(OpRequest, id);
      end else begin
        issue_beat(OpRelease, pick_release_id());
      end
    end
  endtask

  // Sweep pool sizes, including zero and values above the holder capacity.
  task automatic test_size_sweep();
    logic [PoolW-1:0] sizes[12];
    sizes = '{4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd15, 4'd0, 4'd9, 4'd8};
    sizes[11] = PoolW'($urandom_range(0, 15));
    for (int p = 0; p < 12; p++) begin
      write_pool_size(sizes[p]);
      run_traffic(sizes[p] == 0 ? 30 : 70, 40 + 15 * (p % 3), 1'b1);
      // once in the middle, let every result come back before going on
      if (p == 5) drain_results();
    end
    drain_results();
  endtask

  // Back-to-back beats with no sender gaps at the full pool size.
  task automatic test_back_to_back();
    write_pool_size(PoolW'(8));
    run_traffic(110, 55, 1'b0);
    drain_results();
  endtask

  initial begin
    start     = 1'b0;
    req_beat  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_ni    = 1'b0;
    pool_restart(PoolSizeReset);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_handover();
    test_queue_limit();
    test_size_sweep();
    test_back_to_back();

    // let any stray strobe show up before judging
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
